### design/bae_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and command/status types for the block average
// and error tracker. No dependencies.
package bae_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int LEN_W          = 16;
	localparam int BSUM_W         = 48;
	localparam int SOA_W          = 42;
	localparam int SOS_W          = 58;
	localparam int IDX_W          = 10;
	localparam int DIV_W          = 58;
	localparam int DVS_W          = 16;
	localparam int VAR_W          = 48;
	localparam int RAD_W          = 64;
	localparam int ROOT_W         = 32;
	localparam int FRAC_W         = 16;
	localparam int MAX_BLOCKS_DEF = 1024;
	localparam logic [LEN_W-1:0] LEN_RST = 16'd1000;

	typedef enum logic [4:0] {
		S_IDLE, S_AVG, S_AVG_W, S_SQ, S_ACC, S_MEAN, S_MEAN_W, S_MSQ, S_MSQ_W,
		S_M2, S_CLAMP, S_ZERO, S_VAR, S_VAR_W, S_SQRT, S_SQRT_W, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_TAKE, OP_DIV_AVG, OP_GET_AVG, OP_SQUARE, OP_ACC,
		OP_DIV_MEAN, OP_GET_MEAN, OP_DIV_MSQ, OP_GET_MSQ, OP_M2, OP_CLAMP,
		OP_ZERO_ERR, OP_DIV_VAR, OP_GET_VAR, OP_SQRT, OP_GET_ERR, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic blk_end;
		logic drop;
		logic first;
		logic div_done;
		logic sqrt_done;
	} sts_t;

endpackage

### design/bae_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bae_pkg.
module bae_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bae_pkg::DIV_W-1:0] dvd,
	input  logic [bae_pkg::DVS_W-1:0] dvs,
	output logic [bae_pkg::DIV_W-1:0] quo,
	output logic                      done
);
	import bae_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("divider done without run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
endmodule

### design/bae_sqrt.sv
`timescale 1ns / 1ps
// Bit-pair integer square root, one root bit per cycle, floor result.
// Depends on bae_pkg.
module bae_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bae_pkg::RAD_W-1:0]  rad,
	output logic [bae_pkg::ROOT_W-1:0] root,
	output logic                       done
);
	import bae_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q, r2, trial;
	logic [ROOT_W-1:0] root_q;
	logic              fits;

	assign r2    = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign fits  = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? r2 - trial : r2;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

### design/bae_dp.sv
`timescale 1ns / 1ps
// Datapath: accumulators, shared multiplier, divider and square root, output word.
// Depends on bae_pkg, bae_div, bae_sqrt.
module bae_dp #(
	parameter int MAX_BLOCKS = bae_pkg::MAX_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [bae_pkg::LEN_W-1:0]    cfg_data,
	input  logic signed [bae_pkg::SAMPLE_W-1:0] sample,
	input  logic                         restart,
	input  bae_pkg::cmd_t                cmd,
	output bae_pkg::sts_t                sts,
	output logic signed [bae_pkg::SAMPLE_W-1:0] progressive_mean,
	output logic [bae_pkg::ROOT_W-1:0]   mean_error,
	output logic [bae_pkg::IDX_W-1:0]    block_index
);
	import bae_pkg::*;

	localparam int BD_W = $clog2(MAX_BLOCKS + 1);

	logic [LEN_W-1:0]           len_q, len_eff;
	logic [LEN_W-1:0]           sib_q, sib_eff;
	logic signed [BSUM_W-1:0]   bsum_q, bsum_eff, bsum_new;
	logic [BD_W-1:0]            bd_q, bd_eff, n_q;
	logic signed [SOA_W-1:0]    soa_q;
	logic [SOS_W-1:0]           sos_q;
	logic [LEN_W:0]             cnt;
	logic [SAMPLE_W-1:0]        avg_mag_q, mean_mag_q;
	logic signed [SAMPLE_W-1:0] avg_q, mean_q, pm_q;
	logic [2*SAMPLE_W-1:0]      sq_q;
	logic [VAR_W-1:0]           msq_q, var_q, sq_hi;
	logic [ROOT_W-1:0]          err_q, me_q;
	logic [IDX_W-1:0]           bi_q;
	logic [BSUM_W-1:0]          bsum_mag;
	logic [SOA_W-1:0]           soa_mag;
	logic [SAMPLE_W-1:0]        mul_a;
	logic                       div_start, sqrt_start;
	logic [DIV_W-1:0]           dvd, quo;
	logic [DVS_W-1:0]           dvs;
	logic [ROOT_W-1:0]          root;
	logic                       div_done, sqrt_done;

	// restart clears the accumulators and block count before the sample is taken
	assign bsum_eff = restart ? '0 : bsum_q;
	assign sib_eff  = restart ? '0 : sib_q;
	assign bd_eff   = restart ? '0 : bd_q;
	assign len_eff  = (len_q == '0) ? LEN_W'(1) : len_q;
	assign cnt      = {1'b0, sib_eff} + 1'b1;
	assign bsum_new = bsum_eff + BSUM_W'(sample);

	assign bsum_mag = bsum_q[BSUM_W-1] ? BSUM_W'(-bsum_q) : BSUM_W'(bsum_q);
	assign soa_mag  = soa_q[SOA_W-1] ? SOA_W'(-soa_q) : SOA_W'(soa_q);
	assign sq_hi    = sq_q[2*SAMPLE_W-1:FRAC_W];
	assign mul_a    = (cmd.op == OP_M2) ? mean_mag_q : avg_mag_q;

	always_comb begin
		div_start = 1'b0;
		dvd       = '0;
		dvs       = '0;
		case (cmd.op)
			OP_DIV_AVG: begin
				div_start = 1'b1;
				dvd       = DIV_W'(bsum_mag);
				dvs       = sib_q;
			end
			OP_DIV_MEAN: begin
				div_start = 1'b1;
				dvd       = DIV_W'(soa_mag);
				dvs       = DVS_W'(n_q);
			end
			OP_DIV_MSQ: begin
				div_start = 1'b1;
				dvd       = DIV_W'(sos_q);
				dvs       = DVS_W'(n_q);
			end
			OP_DIV_VAR: begin
				div_start = 1'b1;
				dvd       = DIV_W'(var_q);
				dvs       = DVS_W'(n_q - 1'b1);
			end
			default: ;
		endcase
	end

	assign sqrt_start = (cmd.op == OP_SQRT);

	bae_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dvd(dvd), .dvs(dvs), .quo(quo), .done(div_done)
	);

	bae_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.rad({var_q, FRAC_W'(0)}), .root(root), .done(sqrt_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_RST;
			sib_q  <= '0;
			bsum_q <= '0;
			bd_q   <= '0;
			soa_q  <= '0;
			sos_q  <= '0;
		end else begin
			if (cfg_valid)
				len_q <= cfg_data;
			case (cmd.op)
				OP_TAKE: begin
					if (restart) begin
						soa_q <= '0;
						sos_q <= '0;
						bd_q  <= '0;
					end
					if (sts.drop) begin
						bsum_q <= bsum_eff;
						sib_q  <= sib_eff;
					end else begin
						bsum_q <= bsum_new;
						sib_q  <= cnt[LEN_W-1:0];
					end
				end
				OP_ACC: begin
					soa_q  <= soa_q + SOA_W'(avg_q);
					sos_q  <= sos_q + SOS_W'(sq_hi);
					bsum_q <= '0;
					sib_q  <= '0;
				end
				OP_OUT: bd_q <= bd_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_GET_AVG: begin
				avg_mag_q <= quo[SAMPLE_W-1:0];
				avg_q     <= bsum_q[BSUM_W-1] ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
			end
			OP_SQUARE, OP_M2: sq_q <= mul_a * mul_a;
			OP_ACC:     n_q <= bd_q + 1'b1;
			OP_GET_MEAN: begin
				mean_mag_q <= quo[SAMPLE_W-1:0];
				mean_q     <= soa_q[SOA_W-1] ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
			end
			OP_GET_MSQ: msq_q <= quo[VAR_W-1:0];
			OP_CLAMP:   var_q <= (msq_q > sq_hi) ? msq_q - sq_hi : '0;
			OP_GET_VAR: var_q <= quo[VAR_W-1:0];
			OP_GET_ERR: err_q <= root;
			OP_ZERO_ERR: err_q <= '0;
			OP_OUT: begin
				pm_q <= mean_q;
				me_q <= err_q;
				bi_q <= bd_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.blk_end   = cnt >= {1'b0, len_eff};
		sts.drop      = bd_eff >= BD_W'(MAX_BLOCKS);
		sts.first     = (n_q == BD_W'(1));
		sts.div_done  = div_done;
		sts.sqrt_done = sqrt_done;
	end

	assign progressive_mean = pm_q;
	assign mean_error       = me_q;
	assign block_index      = bi_q;
endmodule

### design/bae_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: sequences the block-end arithmetic and owns the handshakes.
// Depends on bae_pkg.
module bae_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  bae_pkg::sts_t sts,
	output bae_pkg::cmd_t cmd
);
	import bae_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = OP_TAKE;
				if (!sts.drop && sts.blk_end)
					state_d = S_AVG;
			end
			S_AVG: begin
				cmd.op  = OP_DIV_AVG;
				state_d = S_AVG_W;
			end
			S_AVG_W: if (sts.div_done) begin
				cmd.op  = OP_GET_AVG;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op  = OP_SQUARE;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = S_MEAN;
			end
			S_MEAN: begin
				cmd.op  = OP_DIV_MEAN;
				state_d = S_MEAN_W;
			end
			S_MEAN_W: if (sts.div_done) begin
				cmd.op  = OP_GET_MEAN;
				state_d = S_MSQ;
			end
			S_MSQ: begin
				cmd.op  = OP_DIV_MSQ;
				state_d = S_MSQ_W;
			end
			S_MSQ_W: if (sts.div_done) begin
				cmd.op  = OP_GET_MSQ;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.op  = OP_M2;
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.op  = OP_CLAMP;
				state_d = sts.first ? S_ZERO : S_VAR;
			end
			S_ZERO: begin
				cmd.op  = OP_ZERO_ERR;
				state_d = S_OUT;
			end
			S_VAR: begin
				cmd.op  = OP_DIV_VAR;
				state_d = S_VAR_W;
			end
			S_VAR_W: if (sts.div_done) begin
				cmd.op  = OP_GET_VAR;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op  = OP_SQRT;
				state_d = S_SQRT_W;
			end
			S_SQRT_W: if (sts.sqrt_done) begin
				cmd.op  = OP_GET_ERR;
				state_d = S_OUT;
			end
			S_OUT: if (!out_valid_q || !out_stall) begin
				cmd.op   = OP_OUT;
				load_out = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_div_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_AVG_W || state_q == S_MEAN_W ||
			state_q == S_MSQ_W || state_q == S_VAR_W))
		else $error("divider finished with nobody waiting");
	a_sqrt_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sqrt_done |-> state_q == S_SQRT_W)
		else $error("root finished with nobody waiting");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result word raised outside output step");
endmodule

### design/block_average_error_tracker_top.sv
`timescale 1ns / 1ps
// Block average and standard error tracker, top level.
// Samples inside a block: accepted one per cycle, no result.
// Block end: input stalls from when the last sample is taken until the result
//   is valid (four divides on the shared divider, a root, five single steps);
//   for the first block of a run three divides, no root, six single steps.
//   A held result adds its stall.
// Reset (arst_n low): all accumulators cleared, block length 1000.
// Depends on bae_pkg, bae_ctrl, bae_dp.
module block_average_error_tracker_top #(
	parameter int MAX_BLOCKS = bae_pkg::MAX_BLOCKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [bae_pkg::SAMPLE_W-1:0] sample,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bae_pkg::SAMPLE_W-1:0] progressive_mean,
	output logic [bae_pkg::ROOT_W-1:0]          mean_error,
	output logic [bae_pkg::IDX_W-1:0]           block_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bae_pkg::LEN_W-1:0]           cfg_data
);
	import bae_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bae_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	bae_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.sample(sample), .restart(restart), .cmd(cmd), .sts(sts),
		.progressive_mean(progressive_mean), .mean_error(mean_error),
		.block_index(block_index)
	);
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for block_average_error_tracker_top: directed and random sample streams,
// checked word by word against a behavioral predictor. Depends on bae_pkg and the top.
module testbench;
	import bae_pkg::*;

	localparam int LIMIT_CYCLES = 6000000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic signed [SAMPLE_W-1:0] mean;
		logic [ROOT_W-1:0]          err;
		logic [IDX_W-1:0]           idx;
	} block_stats_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] progressive_mean;
	logic [ROOT_W-1:0]          mean_error;
	logic [IDX_W-1:0]           block_index;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [LEN_W-1:0]           cfg_data;

	block_stats_t pending_stats[$];
	int errors = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	// predictor state
	logic [LEN_W-1:0] blk_len;
	longint           in_block;
	longint           blk_sum;
	longint           done_blocks;
	longint           avg_sum;
	bit [63:0]        sq_sum;

	block_average_error_tracker_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.progressive_mean(progressive_mean), .mean_error(mean_error),
		.block_index(block_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	function automatic bit [63:0] isqrt(input bit [63:0] v);
		bit [63:0] res = 0;
		bit [63:0] b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] square_q16(input longint a);
		bit [63:0] m;
		m = (a < 0) ? -a : a;
		return (m * m) >> FRAC_W;
	endfunction

	task automatic clear_stats();
		in_block = 0;
		blk_sum = 0;
		done_blocks = 0;
		avg_sum = 0;
		sq_sum = 0;
	endtask

	// expected block statistics for one accepted word
	task automatic predict_block_stats(input logic signed [SAMPLE_W-1:0] s, input logic rs);
		longint eff_len;
		longint avg;
		longint mean;
		bit [63:0] n;
		bit [63:0] msq;
		bit [63:0] m2;
		bit [63:0] var_q;
		bit [63:0] err;
		block_stats_t e;
		if (rs)
			clear_stats();
		if (done_blocks >= MAX_BLOCKS_DEF)
			return;
		blk_sum += longint'(s);
		in_block++;
		eff_len = (blk_len == 0) ? 1 : blk_len;
		if (in_block < eff_len)
			return;
		avg = blk_sum / in_block;
		avg_sum += avg;
		sq_sum += square_q16(avg);
		blk_sum = 0;
		in_block = 0;
		n = done_blocks + 1;
		mean = avg_sum / longint'(n);
		err = 0;
		if (n > 1) begin
			msq = sq_sum / n;
			m2 = square_q16(mean);
			var_q = (msq > m2) ? msq - m2 : 0;
			var_q /= (n - 1);
			err = isqrt(var_q << FRAC_W);
		end
		e.mean = mean[SAMPLE_W-1:0];
		e.err = err[ROOT_W-1:0];
		e.idx = done_blocks[IDX_W-1:0];
		pending_stats.push_back(e);
		done_blocks++;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				report_mismatch("unexpected word", block_index, 0);
			end else begin
				block_stats_t e;
				e = pending_stats.pop_front();
				if (progressive_mean !== e.mean)
					report_mismatch("progressive_mean", progressive_mean, e.mean);
				if (mean_error !== e.err)
					report_mismatch("mean_error", mean_error, e.err);
				if (block_index !== e.idx)
					report_mismatch("block_index", block_index, e.idx);
			end
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic rs);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		restart <= rs;
		do
			@(posedge clk);
		while (in_stall);
		predict_block_stats(s, rs);
	endtask

	// lower valid, drain all results, let the block finish any background work
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_stats.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		blk_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int k;
		k = $urandom_range(99);
		if (k < 40)
			return $urandom;
		if (k < 70)
			return $signed($urandom_range(1048576)) - 524288;
		return 32'sh0003_0000 + $signed($urandom_range(3));
	endfunction

	task automatic test_extremes();
		write_length(1);
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh0000_0000, 1'b0);
		send_sample(32'shffff_ffff, 1'b0);
		send_sample(32'sh0001_0000, 1'b1);
		send_sample(32'sh0001_0000, 1'b0);
		write_length(2);
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(32'sh7fff_ffff, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(-32'sd3, 1'b0);
		send_sample(32'sd0, 1'b0);
	endtask

	task automatic test_length_changes();
		// zero length acts as one
		write_length(0);
		repeat (3) send_sample(rand_sample(), 1'b0);
		// longest length, then shortened mid-block
		write_length(16'hffff);
		repeat (5) send_sample(rand_sample(), 1'b0);
		write_length(2);
		send_sample(rand_sample(), 1'b0);
		write_length(3);
		send_sample(rand_sample(), 1'b1);
		send_sample(rand_sample(), 1'b0);
		write_length(1);
		send_sample(rand_sample(), 1'b0);
	endtask

	task automatic run_random(input int count, input int tx, input int rx);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		write_length(LEN_W'($urandom_range(99) < 10 ? $urandom_range(40, 1) :
			$urandom_range(6, 1)));
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 59)
				write_length(LEN_W'($urandom_range(8)));
			send_sample(rand_sample(), $urandom_range(99) < 3);
		end
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_length(2);
		hold_request = 3000;
		repeat (40) send_sample(rand_sample(), 1'b0);
		// pause until everything has come out
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_stats.size() == 0);
		repeat (10) send_sample(rand_sample(), 1'b0);
	endtask

	task automatic test_exhaustion();
		tx_idle_pct = 0;
		rx_stall_pct = 10;
		write_length(1);
		send_sample(rand_sample(), 1'b1);
		repeat (MAX_BLOCKS_DEF + 5) send_sample(rand_sample(), 1'b0);
		send_sample(rand_sample(), 1'b1);
		send_sample(rand_sample(), 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		restart = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		blk_len = LEN_RST;
		clear_stats();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_length_changes();
		run_random(75, 0, 0);
		run_random(75, 72, 0);
		run_random(75, 0, 72);
		run_random(75, 19, 19);
		test_backpressure();
		test_exhaustion();

		settle();
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
